// ----- rtl/itrt_pkg.sv -----
`default_nettype none

package itrt_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_RADIX   = 36;
  localparam int RADIX_MIN   = 2;
  localparam int RADIX_DEC   = 10;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int STEP_BITS   = 8;
  localparam int DIV_STEPS   = VALUE_BITS / STEP_BITS;
  localparam int STEP_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int CNT_W       = $clog2(VALUE_BITS + 1);
  localparam int JOBQ_DEPTH  = 2;
  localparam int JOBQ_PTR_W  = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int JOBQ_CNT_W  = $clog2(JOBQ_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [DIGIT_W-1:0]           radix;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    logic [DIGIT_W-1:0]    radix;
    logic                  neg;
    logic                  bad;
  } job_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d < DIGIT_W'(RADIX_DEC)) begin
      return CHAR_ZERO + CHAR_W'(d);
    end else begin
      return CHAR_A + CHAR_W'(d) - CHAR_W'(RADIX_DEC);
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itrt_front.sv -----
`default_nettype none

module itrt_front (
  input  wire itrt_pkg::in_req_t in_data,
  output itrt_pkg::job_t         job
);
  import itrt_pkg::*;

  logic sign_bit;
  logic is_dec;

  assign sign_bit = in_data.value[VALUE_BITS-1];
  assign is_dec   = (in_data.radix == DIGIT_W'(RADIX_DEC));

  always_comb begin
    job.radix = in_data.radix;
    job.bad   = !(in_data.radix inside {[RADIX_MIN:MAX_RADIX]});
    job.neg   = sign_bit && is_dec;
    if (sign_bit && is_dec) begin
      job.mag = VALUE_BITS'(0) - VALUE_BITS'(in_data.value);
    end else begin
      job.mag = VALUE_BITS'(in_data.value);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/itrt_jobq.sv -----
`default_nettype none

module itrt_jobq (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  output logic                 full,
  input  wire itrt_pkg::job_t  wdata,
  output logic                 avail,
  input  wire                  pop,
  output itrt_pkg::job_t       rdata
);
  import itrt_pkg::*;

  job_t                  mem_r [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOBQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOBQ_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = (count_r == JOBQ_CNT_W'(JOBQ_DEPTH));
  assign avail   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && avail;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/itrt_back.sv -----
`default_nettype none

module itrt_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   job_avail,
  input  wire itrt_pkg::job_t   job,
  output logic                  job_pop,
  output logic                  out_empty,
  input  wire                   out_pop,
  output itrt_pkg::out_req_t    out_data
);
  import itrt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_DIGIT = 3'd3;
  localparam logic [2:0] ST_END   = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] work_r, work_nxt;
  logic [DIGIT_W-1:0]    rad_r, rad_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [STEP_CNT_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_req_t              out_data_r, out_data_nxt;
  logic [DIGIT_W-1:0]    stk_r [VALUE_BITS];
  logic                  stk_push, stk_pop;

  logic [VALUE_BITS-1:0] div_work;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  adv;

  always_comb begin
    logic [DIGIT_W:0]      t;
    logic [VALUE_BITS-1:0] wk;
    logic                  q;
    wk = work_r;
    t  = {1'b0, rem_r};
    for (int i = 0; i < STEP_BITS; i++) begin
      t  = {t[DIGIT_W-1:0], wk[VALUE_BITS-1]};
      q  = (t >= {1'b0, rad_r});
      if (q) begin
        t = t - {1'b0, rad_r};
      end
      wk = {wk[VALUE_BITS-2:0], q};
    end
    div_work = wk;
    div_rem  = t[DIGIT_W-1:0];
  end

  assign adv       = !out_valid_r || out_pop;
  assign job_pop   = (state_r == ST_IDLE) && job_avail;
  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_data_nxt  = out_data_r;
    stk_push      = 1'b0;
    stk_pop       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (job_avail) begin
          work_nxt = job.mag;
          rad_nxt  = job.radix;
          neg_nxt  = job.neg;
          rem_nxt  = '0;
          step_nxt = '0;
          cnt_nxt  = '0;
          state_nxt = job.bad ? ST_END : ST_DIV;
        end
      end
      ST_DIV: begin
        work_nxt = div_work;
        rem_nxt  = div_rem;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
          stk_push = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          rem_nxt  = '0;
          step_nxt = '0;
          if (div_work == '0 || cnt_r == CNT_W'(VALUE_BITS - 1)) begin
            state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        if (adv) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.character = CHAR_MINUS;
          out_data_nxt.last      = 1'b0;
          state_nxt              = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (adv) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.character = digit_char(stk_r[0]);
          out_data_nxt.last      = 1'b0;
          stk_pop                = 1'b1;
          cnt_nxt                = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_END;
          end
        end
      end
      ST_END: begin
        if (adv) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.character = CHAR_NUL;
          out_data_nxt.last      = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (stk_push) begin
      stk_r[0] <= div_rem;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (stk_pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/integer_to_radix_text.sv -----
// Signed integer to ASCII text in radix 2 to 36.
// Input queue port: drive in_data (value, radix) and in_push; a request is
// taken on a clock edge with in_push high and in_full low. A two-entry job
// queue sits behind the input classifier, so up to two requests wait while
// an earlier one converts.
// Result queue port: while out_empty is low, out_data holds the next
// character; pulse out_pop to take it. Characters come most significant
// first, a '-' leads in radix 10 for negative values, and each request ends
// with a NUL character carrying last. A bad radix yields only the NUL.
// Timing: the divider retires 8 quotient bits per cycle and works through
// all bits of the value for each digit. A request holds the converter
// from leaving the job queue until its NUL is issued; all digits are
// divided out before the sign, the digits and the NUL are sent, so the
// first character appears only after the last digit is divided out.
// On a receiver stall the converter holds its character, dividing on but
// stopping at the next; new requests fill the job queue until in_full rises.
// Reset (rst_n low, synchronous) empties both queues and idles the converter.
`default_nettype none

module integer_to_radix_text (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_push,
  output logic                   in_full,
  input  wire itrt_pkg::in_req_t in_data,
  output logic                   out_empty,
  input  wire                    out_pop,
  output itrt_pkg::out_req_t     out_data
);
  import itrt_pkg::*;

  job_t job_in;
  job_t job_out;
  logic job_avail;
  logic job_pop;

  itrt_front u_front (
    .in_data (in_data),
    .job     (job_in)
  );

  itrt_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (job_in),
    .avail (job_avail),
    .pop   (job_pop),
    .rdata (job_out)
  );

  itrt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (job_avail),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.last) |-> (out_data.character == CHAR_NUL))
    else $error("terminator carries a non-NUL character");

  a_body_not_nul: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.last) |-> (out_data.character != CHAR_NUL))
    else $error("NUL character without last");

  a_full_has_jobs: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> job_avail)
    else $error("input full while job queue is empty");

endmodule

`default_nettype wire
